### rtl/core/vced_pkg.sv
// package for the serpentine variable-coefficient error diffusion block
// holds default sizes, the coefficient type and the coefficient rom
// no dependencies
`default_nettype none
package vced_pkg;

  localparam int unsigned MAX_LINE_WIDTH_DEF = 4096;
  localparam int unsigned FRACTION_BITS_DEF  = 8;
  localparam int unsigned CARRY_WIDTH_DEF    = 20;

  localparam int unsigned LINE_WIDTH_W = 13;
  localparam logic [LINE_WIDTH_W-1:0] LINE_WIDTH_RST = 13'd640;

  localparam int unsigned COEF_W = 12;
  localparam int unsigned SUM_W  = 13;

  typedef struct packed {
    logic [COEF_W-1:0] r;
    logic [COEF_W-1:0] dl;
    logic [SUM_W-1:0]  sum;
  } coef_t;

  localparam coef_t COEF_TABLE [128] = '{
    '{13,0,18},'{13,0,18},'{21,0,31},'{7,0,11},'{8,0,13},'{47,3,78},'{23,3,39},'{15,3,26},
    '{22,6,39},'{43,15,78},'{7,3,13},'{501,224,936},'{249,116,468},'{165,80,312},
    '{123,62,234},'{489,256,936},
    '{81,44,156},'{483,272,936},'{60,35,117},'{53,32,104},'{237,148,468},'{471,304,936},
    '{3,2,6},'{481,314,980},
    '{354,226,735},'{1389,866,2940},'{227,138,490},'{267,158,588},'{327,188,735},
    '{61,34,140},'{627,338,1470},'{1227,638,2940},
    '{20,10,49},'{1937,1000,4704},'{977,520,2352},'{657,360,1568},'{71,40,168},
    '{2005,1160,4704},'{337,200,784},'{2039,1240,4704},
    '{257,160,588},'{691,440,1568},'{1045,680,2352},'{301,200,672},'{177,120,392},
    '{2141,1480,4704},'{1079,760,2352},'{725,520,1568},
    '{137,100,294},'{2209,1640,4704},'{53,40,112},'{2243,1720,4704},'{565,440,1176},
    '{759,600,1568},'{1147,920,2352},'{2311,1880,4704},
    '{97,80,196},'{335,280,672},'{1181,1000,2352},'{793,680,1568},'{599,520,1176},
    '{2413,2120,4704},'{405,360,784},'{2447,2200,4704},
    '{11,10,21},'{158,151,312},'{178,179,364},'{1030,1091,2184},'{248,277,546},
    '{318,375,728},'{458,571,1092},'{878,1159,2184},
    '{5,7,13},'{172,181,390},'{97,76,195},'{72,41,130},'{119,47,195},'{4,1,6},
    '{4,1,6},'{4,1,6},
    '{4,1,6},'{4,1,6},'{4,1,6},'{4,1,6},'{4,1,6},'{4,1,6},'{65,18,100},'{95,29,150},
    '{185,62,300},'{30,11,50},'{35,14,60},'{85,37,150},'{55,26,100},'{80,41,150},
    '{155,86,300},'{5,3,10},
    '{5,3,10},'{5,3,10},'{5,3,10},'{5,3,10},'{5,3,10},'{5,3,10},'{5,3,10},'{5,3,10},
    '{5,3,10},'{5,3,10},'{5,3,10},'{5,3,10},'{305,176,600},'{155,86,300},
    '{105,56,200},'{80,41,150},
    '{65,32,120},'{55,26,100},'{335,152,600},'{85,37,150},'{115,48,200},'{35,14,60},
    '{355,136,600},'{30,11,50},
    '{365,128,600},'{185,62,300},'{25,8,40},'{95,29,150},'{385,112,600},'{65,18,100},
    '{395,104,600},'{4,1,6}
  };

  function automatic coef_t coef_f(input logic [7:0] level);
    logic [6:0] idx;
    idx = level[7] ? ~level[6:0] : level[6:0];
    return COEF_TABLE[idx];
  endfunction

endpackage
`default_nettype wire

### rtl/core/vced_if.sv
// channel interfaces of the error diffusion block: pixel in, halftone out, config
// depends on vced_pkg
`default_nettype none
interface vced_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_value;
  logic       start_of_frame;
  modport source (output valid, pixel_value, start_of_frame, input ready);
  modport sink   (input valid, pixel_value, start_of_frame, output ready);
endinterface

interface vced_out_if;
  logic valid;
  logic ready;
  logic out_white;
  logic row_last;
  modport source (output valid, out_white, row_last, input ready);
  modport sink   (input valid, out_white, row_last, output ready);
endinterface

interface vced_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [vced_pkg::LINE_WIDTH_W-1:0] line_width;
  modport source (output valid, line_width, input ready);
  modport sink   (input valid, line_width, output ready);
endinterface
`default_nettype wire

### rtl/core/vced_ram.sv
// single-port synchronous carry line memory, registered read data
// no dependencies
`default_nettype none
module vced_ram #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned WIDTH = 20
) (
  input  wire logic                     clk_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic                     re_i,
  input  wire logic                     we_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[addr_i];
    end
  end

endmodule
`default_nettype wire

### rtl/core/vced_div.sv
// restoring divider, one quotient bit per cycle, unsigned
// no dependencies
`default_nettype none
module vced_div #(
  parameter int unsigned NW = 36,
  parameter int unsigned DW = 13
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [NW-1:0] dividend_i,
  input  wire logic [DW-1:0] divisor_i,
  output      logic          done_o,
  output      logic [NW-1:0] quot_o
);

  localparam int unsigned CNT_W = $clog2(NW + 1);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [NW-1:0]    acc_q, acc_d;
  logic [DW-1:0]    rem_q, rem_d;
  logic [DW-1:0]    div_q, div_d;
  logic [DW:0]      trial;
  logic             qbit;

  always_comb begin
    trial  = {rem_q, acc_q[NW-1]};
    qbit   = trial >= {1'b0, div_q};
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    acc_d  = acc_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (start_i) begin
      cnt_d  = CNT_W'(NW);
      busy_d = 1'b1;
      acc_d  = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = qbit ? DW'(trial - {1'b0, div_q}) : trial[DW-1:0];
      acc_d = {acc_q[NW-2:0], qbit};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign done_o = done_q;
  assign quot_o = acc_q;

endmodule
`default_nettype wire

### rtl/core/variable_coefficient_error_diffusion.sv
// serpentine variable-coefficient error diffusion, top level
// depends on vced_pkg, vced_if, vced_ram, vced_div
//
// usage:
//   in_i   words carry an 8-bit grey pixel in serpentine order and a start of
//          frame flag; out_o words carry the halftone bit and a row end flag,
//          one out word per in word, in order
//   cfg_i  writes line_width (pixels per row); write it only while idle
// timing:
//   one pixel at a time; an accepted pixel passes ST_RD, ST_MUL, ST_STRT, ST_DIV,
//   ST_WR1 and ST_WR2, which registers the out word and returns to ST_IDLE for the
//   next pixel; ST_DIV waits on the bit-serial division of the two error shares
//   by the coefficient sum; a row end adds a clearing pass over the retiring
//   line's span; carries live in two line memories that swap roles at each row end
// reset:
//   line_width returns to 640, scan position to the first pixel of a frame;
//   both line memories are zeroed over all 2**AW entries (4096) with in_i.ready low
// stall:
//   the finished word waits in the out register; a new pixel is taken while
//   it waits, and that pixel holds before its write-back until out_o drains
`default_nettype none
module variable_coefficient_error_diffusion #(
  parameter int unsigned MAX_LINE_WIDTH = vced_pkg::MAX_LINE_WIDTH_DEF,
  parameter int unsigned FRACTION_BITS  = vced_pkg::FRACTION_BITS_DEF,
  parameter int unsigned CARRY_WIDTH    = vced_pkg::CARRY_WIDTH_DEF
) (
  input wire logic   clk_i,
  input wire logic   rst_ni,
  vced_in_if.sink    in_i,
  vced_out_if.source out_o,
  vced_cfg_if.sink   cfg_i
);
  import vced_pkg::*;

  localparam int unsigned AW = $clog2(MAX_LINE_WIDTH);
  localparam int unsigned WW = AW + 1;
  localparam int unsigned CW = CARRY_WIDTH;
  localparam int unsigned F  = FRACTION_BITS;
  localparam int unsigned CORR_W = ((CW > F + 9) ? CW : F + 9) + 1;
  localparam int unsigned EW = CORR_W + 3;
  localparam int unsigned PROD_W = EW + COEF_W;

  localparam logic signed [EW-1:0] SAT_HI = {{(EW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [EW-1:0] SAT_LO = ~SAT_HI;
  localparam logic signed [EW-1:0] THR =
    {{(EW-8-F+1){1'b0}}, 8'hFF, {(F-1){1'b0}}};
  localparam logic signed [EW-1:0] WHITE_LVL = {{(EW-8-F){1'b0}}, 8'hFF, {F{1'b0}}};

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RD   = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_STRT = 3'd3;
  localparam logic [2:0] ST_DIV  = 3'd4;
  localparam logic [2:0] ST_WR1  = 3'd5;
  localparam logic [2:0] ST_WR2  = 3'd6;
  localparam logic [2:0] ST_CLR  = 3'd7;

  function automatic logic signed [EW-1:0] sx_f(input logic signed [CW-1:0] v);
    return {{(EW-CW){v[CW-1]}}, v};
  endfunction

  function automatic logic signed [CW-1:0] sat_f(input logic signed [EW-1:0] v);
    logic signed [CW-1:0] r;
    if (v > SAT_HI) r = SAT_HI[CW-1:0];
    else if (v < SAT_LO) r = SAT_LO[CW-1:0];
    else r = v[CW-1:0];
    return r;
  endfunction

  // control state
  logic [2:0]              state_q, state_d;
  logic [LINE_WIDTH_W-1:0] lw_q;
  logic [AW-1:0]           pos_q, pos_d;
  logic                    odd_q, odd_d;
  logic                    first_q, first_d;
  logic signed [CW-1:0]    fwd_q, fwd_d;
  logic                    bank_q, bank_d;
  logic                    crv_q, crv_d, nrv_q, nrv_d;
  logic [AW-1:0]           clo_q, clo_d, chi_q, chi_d, nlo_q, nlo_d, nhi_q, nhi_d;
  logic                    oval_q, oval_d;
  logic                    owhite_q, owhite_d, olast_q, olast_d;
  logic [AW-1:0]           clr_q, clr_d, clr_hi_q, clr_hi_d;
  logic                    clr_all_q, clr_all_d;

  // item registers
  logic [7:0]              pix_q;
  logic [AW-1:0]           k_q, col_q, bcol_q;
  logic                    last_q, ifirst_q;
  logic signed [CW-1:0]    ifwd_q;
  logic signed [EW-1:0]    diff_q, olddn_q, bst_q, dn_q;
  logic                    white_q;
  coef_t                   coef_q;
  logic [PROD_W-1:0]       prod_r_q, prod_d_q;
  logic signed [CW-1:0]    rt_sat_q;

  // width and position
  logic [31:0]             lw_ext;
  logic [WW-1:0]           w_eff, k_w, col_w, bcol_w;
  logic [AW-1:0]           k0;
  logic                    odd_e;
  logic                    accept;

  always_comb begin
    lw_ext = {{(32-LINE_WIDTH_W){1'b0}}, lw_q};
    if (lw_ext == 32'd0) w_eff = WW'(1);
    else if (lw_ext > MAX_LINE_WIDTH) w_eff = WW'(MAX_LINE_WIDTH);
    else w_eff = WW'(lw_ext);
    k0     = in_i.start_of_frame ? '0 : pos_q;
    odd_e  = in_i.start_of_frame ? 1'b0 : odd_q;
    k_w    = ({1'b0, k0} >= w_eff) ? w_eff - 1'b1 : {1'b0, k0};
    col_w  = odd_e ? w_eff - 1'b1 - k_w : k_w;
    bcol_w = odd_e ? col_w + 1'b1 : col_w - 1'b1;
  end

  assign accept      = (state_q == ST_IDLE) && in_i.valid;
  assign in_i.ready  = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;

  // memories
  logic [AW-1:0]  ram_addr [2];
  logic           ram_re [2], ram_we [2];
  logic [CW-1:0]  ram_wd [2], ram_rd [2];
  logic [AW-1:0]  cur_addr, nxt_addr;
  logic           cur_re, cur_we, nxt_re, nxt_we;
  logic [CW-1:0]  nxt_wd;
  logic signed [CW-1:0] cur_rd, nxt_rd;

  for (genvar g = 0; g < 2; g++) begin : g_ram
    vced_ram #(.DEPTH(2**AW), .WIDTH(CW)) u_ram (
      .clk_i   (clk_i),
      .addr_i  (ram_addr[g]),
      .re_i    (ram_re[g]),
      .we_i    (ram_we[g]),
      .wdata_i (ram_wd[g]),
      .rdata_o (ram_rd[g])
    );
  end

  always_comb begin
    ram_addr[0] = bank_q ? nxt_addr : cur_addr;
    ram_re[0]   = bank_q ? nxt_re : cur_re;
    ram_we[0]   = bank_q ? nxt_we : cur_we;
    ram_wd[0]   = bank_q ? nxt_wd : '0;
    ram_addr[1] = bank_q ? cur_addr : nxt_addr;
    ram_re[1]   = bank_q ? cur_re : nxt_re;
    ram_we[1]   = bank_q ? cur_we : nxt_we;
    ram_wd[1]   = bank_q ? '0 : nxt_wd;
    cur_rd      = bank_q ? ram_rd[1] : ram_rd[0];
    nxt_rd      = bank_q ? ram_rd[0] : ram_rd[1];
  end

  // dividers
  logic [PROD_W-1:0] q_r, q_d;
  logic              div_start, div_done, div_done_d;

  assign div_start = (state_q == ST_STRT);

  vced_div #(.NW(PROD_W), .DW(SUM_W)) u_div_r (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(prod_r_q),
    .divisor_i(coef_q.sum), .done_o(div_done), .quot_o(q_r)
  );

  vced_div #(.NW(PROD_W), .DW(SUM_W)) u_div_d (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(prod_d_q),
    .divisor_i(coef_q.sum), .done_o(div_done_d), .quot_o(q_d)
  );

  // datapath
  logic signed [EW-1:0] stored, carry_x, pix_fx, corr, diff, olddn;
  logic signed [CW-1:0] carry;
  logic                 white;
  logic [EW-1:0]        dmag;
  logic signed [EW-1:0] rt, dt, qr_s, qd_s, dn;
  logic                 out_free;

  always_comb begin
    stored  = ifirst_q ? '0 : sx_f(cur_rd);
    carry   = sat_f(stored + sx_f(ifwd_q));
    carry_x = sx_f(carry);
    pix_fx  = {{(EW-8-F){1'b0}}, pix_q, {F{1'b0}}};
    corr    = pix_fx + carry_x;
    white   = corr > THR;
    diff    = white ? corr - WHITE_LVL : corr;
    olddn   = ifirst_q ? '0 : sx_f(nxt_rd);
    dmag    = diff_q[EW-1] ? EW'(-diff_q) : EW'(diff_q);
    qr_s    = $signed(q_r[EW-1:0]);
    qd_s    = $signed(q_d[EW-1:0]);
    rt      = diff_q[EW-1] ? -qr_s : qr_s;
    dt      = diff_q[EW-1] ? -qd_s : qd_s;
    dn      = diff_q - rt - dt;
    out_free = !oval_q || out_o.ready;
  end

  always_comb begin
    cur_addr = col_w[AW-1:0];
    cur_re   = accept;
    cur_we   = 1'b0;
    nxt_addr = col_w[AW-1:0];
    nxt_re   = accept;
    nxt_we   = 1'b0;
    nxt_wd   = sat_f(olddn_q + dn_q);
    unique case (state_q)
      ST_RD: begin
        nxt_addr = bcol_q;
        nxt_re   = 1'b1;
      end
      ST_MUL: begin
        cur_addr = col_q;
        cur_we   = 1'b1;
      end
      ST_WR1: begin
        nxt_addr = bcol_q;
        nxt_we   = (k_q != '0);
        nxt_wd   = sat_f(bst_q + dt);
      end
      ST_WR2: begin
        nxt_addr = col_q;
        nxt_we   = out_free;
      end
      ST_CLR: begin
        cur_addr = clr_q;
        cur_we   = clr_all_q;
        nxt_addr = clr_q;
        nxt_we   = 1'b1;
        nxt_wd   = '0;
      end
      default: ;
    endcase
  end

  // sequencer
  logic [AW-1:0] lo_x, hi_x;
  logic          v_x;

  always_comb begin
    state_d   = state_q;
    pos_d     = pos_q;
    odd_d     = odd_q;
    first_d   = first_q;
    fwd_d     = fwd_q;
    bank_d    = bank_q;
    crv_d     = crv_q;
    clo_d     = clo_q;
    chi_d     = chi_q;
    nrv_d     = nrv_q;
    nlo_d     = nlo_q;
    nhi_d     = nhi_q;
    oval_d    = oval_q && !out_o.ready;
    owhite_d  = owhite_q;
    olast_d   = olast_q;
    clr_d     = clr_q;
    clr_hi_d  = clr_hi_q;
    clr_all_d = clr_all_q;
    lo_x      = nlo_q;
    hi_x      = nhi_q;
    v_x       = nrv_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_RD;
          if (in_i.start_of_frame) begin
            pos_d   = '0;
            odd_d   = 1'b0;
            first_d = 1'b1;
            fwd_d   = '0;
          end
        end
      end
      ST_RD:   state_d = ST_MUL;
      ST_MUL:  state_d = ST_STRT;
      ST_STRT: state_d = ST_DIV;
      ST_DIV: begin
        if (div_done && div_done_d) begin
          state_d = ST_WR1;
        end
      end
      ST_WR1: begin
        state_d = ST_WR2;
        if (k_q != '0) begin
          nrv_d = 1'b1;
          nlo_d = (!nrv_q || bcol_q < nlo_q) ? bcol_q : nlo_q;
          nhi_d = (!nrv_q || bcol_q > nhi_q) ? bcol_q : nhi_q;
        end
      end
      ST_WR2: begin
        if (out_free) begin
          state_d  = ST_IDLE;
          oval_d   = 1'b1;
          owhite_d = (pix_q != 8'd0) && white_q;
          olast_d  = last_q;
          v_x  = 1'b1;
          lo_x = (!nrv_q || col_q < nlo_q) ? col_q : nlo_q;
          hi_x = (!nrv_q || col_q > nhi_q) ? col_q : nhi_q;
          if (last_q) begin
            // retiring line is cleared over the span it was written in
            if (crv_q) begin
              state_d   = ST_CLR;
              clr_d     = clo_q;
              clr_hi_d  = chi_q;
              clr_all_d = 1'b0;
            end
            bank_d  = ~bank_q;
            crv_d   = v_x;
            clo_d   = lo_x;
            chi_d   = hi_x;
            nrv_d   = 1'b0;
            pos_d   = '0;
            odd_d   = ~odd_q;
            first_d = 1'b0;
            fwd_d   = '0;
          end else begin
            nrv_d = v_x;
            nlo_d = lo_x;
            nhi_d = hi_x;
            pos_d = k_q + 1'b1;
            fwd_d = rt_sat_q;
          end
        end
      end
      ST_CLR: begin
        if (clr_q == clr_hi_q) begin
          state_d   = ST_IDLE;
          clr_all_d = 1'b0;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLR;
      lw_q      <= LINE_WIDTH_RST;
      pos_q     <= '0;
      odd_q     <= 1'b0;
      first_q   <= 1'b1;
      fwd_q     <= '0;
      bank_q    <= 1'b0;
      crv_q     <= 1'b0;
      clo_q     <= '0;
      chi_q     <= '0;
      nrv_q     <= 1'b0;
      nlo_q     <= '0;
      nhi_q     <= '0;
      oval_q    <= 1'b0;
      owhite_q  <= 1'b0;
      olast_q   <= 1'b0;
      clr_q     <= '0;
      clr_hi_q  <= '1;
      clr_all_q <= 1'b1;
    end else begin
      state_q  <= state_d;
      if (cfg_i.valid) begin
        lw_q <= cfg_i.line_width;
      end
      pos_q     <= pos_d;
      odd_q     <= odd_d;
      first_q   <= first_d;
      fwd_q     <= fwd_d;
      bank_q    <= bank_d;
      crv_q     <= crv_d;
      clo_q     <= clo_d;
      chi_q     <= chi_d;
      nrv_q     <= nrv_d;
      nlo_q     <= nlo_d;
      nhi_q     <= nhi_d;
      oval_q    <= oval_d;
      owhite_q  <= owhite_d;
      olast_q   <= olast_d;
      clr_q     <= clr_d;
      clr_hi_q  <= clr_hi_d;
      clr_all_q <= clr_all_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pix_q    <= in_i.pixel_value;
      k_q      <= k_w[AW-1:0];
      col_q    <= col_w[AW-1:0];
      bcol_q   <= bcol_w[AW-1:0];
      last_q   <= (k_w + 1'b1 >= w_eff);
      ifirst_q <= in_i.start_of_frame ? 1'b1 : first_q;
      ifwd_q   <= in_i.start_of_frame ? '0 : fwd_q;
    end
    if (state_q == ST_RD) begin
      diff_q  <= diff;
      white_q <= white;
      olddn_q <= olddn;
      coef_q  <= coef_f(pix_q);
    end
    if (state_q == ST_MUL) begin
      prod_r_q <= PROD_W'(coef_q.r) * PROD_W'(dmag);
      prod_d_q <= PROD_W'(coef_q.dl) * PROD_W'(dmag);
      bst_q    <= sx_f(nxt_rd);
    end
    if (state_q == ST_WR1) begin
      dn_q     <= dn;
      rt_sat_q <= sat_f(rt);
    end
  end

  assign out_o.valid     = oval_q;
  assign out_o.out_white = owhite_q;
  assign out_o.row_last  = olast_q;

endmodule
`default_nettype wire
